@@ src/clqf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqf_pkg
// Shared sizes, codes, types and helpers of the quantity FIFO.
// ----------------------------------------------------------------------------
package clqf_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 16;

  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int AmtW  = 32;
  localparam int IdW   = 16;
  localparam int CmdW  = 2;
  localparam int TakeW = 5;
  localparam int StatW = 3;
  localparam int TolW  = 16;
  localparam int AddrW = 4;
  localparam int DataW = 32;
  localparam int EntW  = ID_BITS + AmtW;
  localparam int ResW  = IdW + AmtW;

  localparam logic [CmdW-1:0] CMD_ADD     = 2'd0;
  localparam logic [CmdW-1:0] CMD_REM_AMT = 2'd1;
  localparam logic [CmdW-1:0] CMD_REM_CNT = 2'd2;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_OVER_CAP = 3'd1;
  localparam logic [StatW-1:0] ST_DUP_ID   = 3'd2;
  localparam logic [StatW-1:0] ST_AMT_ERR  = 3'd3;
  localparam logic [StatW-1:0] ST_CNT_ERR  = 3'd4;

  localparam logic [1:0] REG_LIMIT_OFF = 2'd0;
  localparam logic [1:0] REG_CAPACITY  = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WALK,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  typedef struct packed {
    logic            limit_off;
    logic [AmtW-1:0] capacity;
    logic [TolW-1:0] tolerance;
  } cfg_t;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

@@ src/clqf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqf_item_if / clqf_result_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface clqf_item_if;
  import clqf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [IdW-1:0]   item_id;
  logic [AmtW-1:0]  amount;
  logic [TakeW-1:0] take_count;

  modport source(output valid, cmd, item_id, amount, take_count, input ready);
  modport sink(input valid, cmd, item_id, amount, take_count, output ready);
endinterface

interface clqf_result_if;
  import clqf_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdW-1:0]   out_id;
  logic [AmtW-1:0]  out_amount;
  logic             last;
  logic [StatW-1:0] status;
  logic [AmtW-1:0]  stored_total;
  logic [TakeW-1:0] entry_count;
  logic [AmtW-1:0]  free_space;

  modport source(output valid, out_id, out_amount, last, status, stored_total,
                 entry_count, free_space, input ready);
  modport sink(input valid, out_id, out_amount, last, status, stored_total,
               entry_count, free_space, output ready);
endinterface

@@ src/capacity_limited_quantity_fifo_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_limited_quantity_fifo_top
// Quantity FIFO with running total, capacity check and partial dequeue.
// ----------------------------------------------------------------------------
// Add: a check, then an id scan over the stored entries (skipped on a capacity
// error), then a read and a load of the result beat. Remove: a check, then a
// walk over the popped or split entries (none if nothing leaves), then a read and
// a load per result beat. Next command is accepted the cycle after the last load.
// rst (synchronous) clears pointers, count, total and registers; entry data
// is not cleared and is read only after being written.
module capacity_limited_quantity_fifo_top (
  input  logic                       clk,
  input  logic                       rst,
  clqf_item_if.sink                  item,
  clqf_result_if.source              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [clqf_pkg::AddrW-1:0] paddr,
  input  logic [clqf_pkg::DataW-1:0] pwdata,
  output logic [clqf_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import clqf_pkg::*;

  cfg_t cfg;

  clqf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clqf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

endmodule

@@ src/clqf_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqf_cfg
// APB register file: limit_off, capacity, tolerance.
// ----------------------------------------------------------------------------
module clqf_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [clqf_pkg::AddrW-1:0] paddr,
  input  logic [clqf_pkg::DataW-1:0] pwdata,
  output logic [clqf_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output clqf_pkg::cfg_t             cfg
);
  import clqf_pkg::*;

  logic            limit_off;
  logic [AmtW-1:0] capacity;
  logic [TolW-1:0] tolerance;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_off <= 1'b0;
      capacity  <= '0;
      tolerance <= TolW'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LIMIT_OFF: limit_off <= pwdata[0];
        REG_CAPACITY:  capacity  <= pwdata[AmtW-1:0];
        REG_TOLERANCE: tolerance <= pwdata[TolW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIMIT_OFF: prdata = DataW'(limit_off);
      REG_CAPACITY:  prdata = DataW'(capacity);
      REG_TOLERANCE: prdata = DataW'(tolerance);
      default:       prdata = '0;
    endcase
  end

  assign cfg.limit_off = limit_off;
  assign cfg.capacity  = capacity;
  assign cfg.tolerance = tolerance;

endmodule

@@ src/clqf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqf_ctrl
// Command sequencer around the entry memory and the result buffer.
// ----------------------------------------------------------------------------
module clqf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  clqf_pkg::cfg_t cfg,
  clqf_item_if.sink      item,
  clqf_result_if.source  result
);
  import clqf_pkg::*;

  state_t state, state_next;

  // latched command
  logic [CmdW-1:0]    cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [AmtW-1:0]    amt_r;
  logic [TakeW-1:0]   take_r;
  logic [StatW-1:0]   status_r;

  // fifo state
  logic [PtrW-1:0]    head;
  logic [PtrW-1:0]    tail;
  logic [CntW-1:0]    stored;
  logic [AmtW-1:0]    total;

  // walk / scan
  logic signed [33:0] left;
  logic [PtrW-1:0]    rd_ptr;
  logic               rd_vld;
  logic [CntW-1:0]    sc_iss;
  logic [CntW-1:0]    res_n;
  logic [CntW-1:0]    emit_k;

  // memories
  logic [EntW-1:0]    ent_mem [DEPTH];
  logic [EntW-1:0]    ent_rd;
  logic [ResW-1:0]    res_mem [DEPTH];
  logic [ResW-1:0]    res_rd;

  // output register
  logic               o_valid;
  logic [IdW-1:0]     o_id;
  logic [AmtW-1:0]    o_amt;
  logic               o_last;
  logic [StatW-1:0]   o_status;
  logic [AmtW-1:0]    o_total;
  logic [TakeW-1:0]   o_count;
  logic [AmtW-1:0]    o_free;

  logic               accept;
  logic               out_free;
  logic               rd_en;
  logic               sc_issue;
  logic               scan_hit;
  logic               scan_end;
  logic               full;
  logic               add_ok;
  logic               walk_step;
  logic               walk_more;
  logic               whole;
  logic               emit_last;
  logic               add_cap_err;
  logic               add_ovf;
  logic               rem_amt_err;
  logic               cnt_err;
  logic               amt_pending;
  logic [ID_BITS-1:0] ent_id;
  logic [AmtW-1:0]    ent_amt;
  logic [AmtW-1:0]    res_amt;
  logic [AmtW-1:0]    free_now;
  logic [AmtW:0]      add_sum;
  logic signed [33:0] tol_s;
  logic signed [33:0] diff_w;
  logic signed [33:0] left_new;
  logic signed [34:0] add_excess;
  logic signed [34:0] tol_w;
  logic [PtrW+1:0]    ring_sum;
  logic [PtrW+1:0]    ring_tail;

  assign accept   = item.valid && item.ready;
  assign out_free = !o_valid || result.ready;

  assign ent_id  = ent_rd[EntW-1:AmtW];
  assign ent_amt = ent_rd[AmtW-1:0];

  assign tol_s = $signed({18'b0, cfg.tolerance});
  assign tol_w = $signed({19'b0, cfg.tolerance});

  assign add_excess  = $signed({3'b0, amt_r}) - $signed({3'b0, cfg.capacity})
                     + $signed({3'b0, total});
  assign add_cap_err = !cfg.limit_off && (add_excess > tol_w);
  assign add_sum     = {1'b0, total} + {1'b0, amt_r};
  assign add_ovf     = add_sum[AmtW];
  assign rem_amt_err = ($signed({2'b0, amt_r}) - $signed({2'b0, total})) > tol_s;
  assign cnt_err     = 32'(take_r) > 32'(stored);
  assign amt_pending = ($signed({2'b0, amt_r}) > tol_s) && (stored != '0);

  assign sc_issue = (state == S_SCAN) && (sc_iss < stored);
  assign scan_hit = (state == S_SCAN) && rd_vld && (ent_id == id_r);
  assign scan_end = scan_hit || ((sc_iss == stored) && !rd_vld);
  assign full     = (stored == CntW'(DEPTH));
  assign add_ok   = (state == S_SCAN) && scan_end && !scan_hit && !full;

  assign walk_step = (state == S_WALK) && rd_vld;
  assign diff_w    = $signed({2'b0, ent_amt}) - left;
  assign whole     = (cmd_r == CMD_REM_CNT) || (diff_w <= tol_s);
  assign left_new  = left - $signed({2'b0, ent_amt});
  assign res_amt   = whole ? ent_amt : left[AmtW-1:0];

  always_comb begin
    if (cmd_r == CMD_REM_CNT) begin
      walk_more = (32'(res_n) + 32'd1) < 32'(take_r);
    end else begin
      walk_more = whole && (left_new > tol_s) && (stored != CntW'(1));
    end
  end

  assign emit_last = (32'(emit_k) + 32'd1) >= 32'(res_n);

  always_comb begin
    if (cfg.limit_off) begin
      free_now = '1;
    end else if (cfg.capacity >= total) begin
      free_now = cfg.capacity - total;
    end else begin
      free_now = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (cmd_r)
          CMD_ADD: begin
            state_next = (add_cap_err || add_ovf) ? S_EMIT_RD : S_SCAN;
          end
          CMD_REM_AMT: begin
            state_next = (!rem_amt_err && amt_pending) ? S_WALK : S_EMIT_RD;
          end
          CMD_REM_CNT: begin
            state_next = (cnt_err || take_r == '0) ? S_EMIT_RD : S_WALK;
          end
          default: state_next = S_EMIT_RD;
        endcase
      end
      S_SCAN: begin
        if (scan_end) state_next = S_EMIT_RD;
      end
      S_WALK: begin
        if (walk_step && !walk_more) state_next = S_EMIT_RD;
      end
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        if (out_free) state_next = emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item.ready = (state == S_IDLE);
    rd_en      = sc_issue || (state == S_WALK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      stored   <= '0;
      total    <= '0;
      status_r <= ST_OK;
      rd_vld   <= 1'b0;
      sc_iss   <= '0;
      res_n    <= '0;
      emit_k   <= '0;
      o_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (accept) begin
        status_r <= ST_OK;
        sc_iss   <= '0;
        res_n    <= '0;
        emit_k   <= '0;
      end
      if (state == S_CHECK) begin
        if (cmd_r == CMD_ADD && (add_cap_err || add_ovf)) status_r <= ST_OVER_CAP;
        if (cmd_r == CMD_REM_AMT && rem_amt_err) status_r <= ST_AMT_ERR;
        if (cmd_r == CMD_REM_CNT && cnt_err) status_r <= ST_CNT_ERR;
      end
      if (sc_issue) sc_iss <= sc_iss + 1'b1;
      if (state == S_SCAN && scan_end) begin
        if (scan_hit) begin
          status_r <= ST_DUP_ID;
        end else if (full) begin
          status_r <= ST_OVER_CAP;
        end
      end
      if (add_ok) begin
        tail   <= next_ptr(tail);
        stored <= stored + 1'b1;
        total  <= add_sum[AmtW-1:0];
      end
      if (walk_step) begin
        res_n <= res_n + 1'b1;
        if (whole) begin
          total  <= total - ent_amt;
          head   <= next_ptr(head);
          stored <= stored - 1'b1;
        end else begin
          total <= total - left[AmtW-1:0];
        end
      end
      if (state == S_EMIT_LD && out_free) emit_k <= emit_k + 1'b1;
      if (state == S_EMIT_LD && out_free) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= item.cmd;
      id_r   <= ID_BITS'(item.item_id);
      amt_r  <= item.amount;
      take_r <= item.take_count;
      left   <= $signed({2'b0, item.amount});
      rd_ptr <= head;
    end else begin
      if (rd_en) rd_ptr <= next_ptr(rd_ptr);
      if (walk_step) left <= left_new;
    end
    if (state == S_EMIT_LD && out_free) begin
      o_id     <= (res_n == '0) ? '0 : res_rd[ResW-1:AmtW];
      o_amt    <= (res_n == '0) ? '0 : res_rd[AmtW-1:0];
      o_last   <= emit_last;
      o_status <= status_r;
      o_total  <= total;
      o_count  <= TakeW'(stored);
      o_free   <= free_now;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (add_ok) begin
      ent_mem[tail] <= {id_r, amt_r};
    end else if (walk_step && !whole) begin
      ent_mem[head] <= {ent_id, ent_amt - left[AmtW-1:0]};
    end
    if (rd_en) ent_rd <= ent_mem[rd_ptr];
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (walk_step) res_mem[res_n[PtrW-1:0]] <= {IdW'(ent_id), res_amt};
    if (state == S_EMIT_RD) res_rd <= res_mem[emit_k[PtrW-1:0]];
  end

  assign result.valid        = o_valid;
  assign result.out_id       = o_id;
  assign result.out_amount   = o_amt;
  assign result.last         = o_last;
  assign result.status       = o_status;
  assign result.stored_total = o_total;
  assign result.entry_count  = o_count;
  assign result.free_space   = o_free;

  assign ring_sum  = (PtrW+2)'(head) + (PtrW+2)'(stored);
  assign ring_tail = (ring_sum >= (PtrW+2)'(DEPTH)) ? ring_sum - (PtrW+2)'(DEPTH)
                                                   : ring_sum;

  a_stored_max: assert property (@(posedge clk) disable iff (rst)
    stored <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_ring: assert property (@(posedge clk) disable iff (rst)
    tail == ring_tail[PtrW-1:0])
    else $error("tail does not match head plus count");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    walk_step |-> stored != '0)
    else $error("walk step on empty fifo");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_n <= CntW'(DEPTH))
    else $error("result buffer overrun");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !result.ready && state == S_EMIT_LD) |=> $stable(o_amt))
    else $error("pending beat overwritten");

endmodule
